// ----- rtl/lfa_pkg.sv -----
// Package for the lowest-free identifier allocator.
// Holds sizes, request kind and status codes, and bitmap helper functions.
// No dependencies.
package lfa_pkg;

  localparam int unsigned IdCount     = 1024;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned NumWords    = (IdCount + WordBits - 1) / WordBits;
  localparam int unsigned IdW         = 10;
  localparam int unsigned KindW       = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned WordIdxW    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned BitIdxW     = $clog2(WordBits);
  localparam int unsigned LastWordIds = IdCount - (NumWords - 1) * WordBits;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [NumWords-1:0] words_t;
  typedef logic [WordIdxW-1:0] word_idx_t;
  typedef logic [BitIdxW-1:0]  bit_idx_t;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOT_LIVE = 2'd2
  } status_e;

  // Ones at bit positions of a word that lie at or above IdCount.
  function automatic word_t pad_mask(input word_idx_t w);
    word_t m;
    m = '0;
    if (32'(w) == NumWords - 1) begin
      for (int i = 0; i < WordBits; i++) begin
        if (i >= LastWordIds) m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  // Lowest zero bit of a word.
  function automatic bit_idx_t find_first_zero(input word_t v);
    bit_idx_t idx;
    idx = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!v[i]) idx = BitIdxW'(i);
    end
    return idx;
  endfunction

  // Lowest set bit of the summary vector.
  function automatic word_idx_t find_first_one(input words_t v);
    word_idx_t idx;
    idx = '0;
    for (int i = NumWords - 1; i >= 0; i--) begin
      if (v[i]) idx = WordIdxW'(i);
    end
    return idx;
  endfunction

endpackage

// ----- rtl/lfa_req_if.sv -----
// Request channel of the allocator: valid/ready plus kind and release id.
// Depends on lfa_pkg.
interface lfa_req_if import lfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [IdW-1:0]   release_id;

  modport source (output valid, output kind, output release_id, input ready);
  modport sink   (input valid, input kind, input release_id, output ready);
endinterface

// ----- rtl/lfa_rsp_if.sv -----
// Response channel of the allocator: valid/ready plus id and status.
// Depends on lfa_pkg.
interface lfa_rsp_if import lfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IdW-1:0]     id;
  logic [StatusW-1:0] status;

  modport source (output valid, output id, output status, input ready);
  modport sink   (input valid, input id, input status, output ready);
endinterface

// ----- rtl/lowest_free_id_allocator.sv -----
// Lowest-free identifier allocator. Each request item yields one response item. An item
// is handled in two steps: on accept one bitmap word is read from a synchronous memory (the
// word picked by the per-word free summary for allocate, by the id for release); then, once
// the response register is free or drained, the word is searched, written back and the
// response register loaded. The single memory read port and its registered read set this
// order; a further item is taken only after the return to idle, while that response waits.
// Clear takes effect at once through per-word valid bits, so no sweep follows reset.
// Depends on lfa_pkg, lfa_req_if and lfa_rsp_if.
module lowest_free_id_allocator import lfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lfa_req_if.sink   req_i,
  lfa_rsp_if.source rsp_o
);

  typedef enum logic {ST_IDLE, ST_LOOK} state_e;

  state_e           state_q;
  logic [KindW-1:0] kind_q;
  logic [IdW-1:0]   rel_id_q;
  word_idx_t        widx_q;
  logic             none_free_q;
  words_t           sum_q;
  words_t           vld_q;
  logic             rsp_valid_q;
  logic [IdW-1:0]   rsp_id_q;
  logic [StatusW-1:0] rsp_status_q;
  logic [IdW-1:0]   rsp_id_d;
  logic [StatusW-1:0] rsp_status_d;

  word_t            mem [NumWords];
  word_t            rdata_q;

  logic             accept;
  logic             advance;
  word_idx_t        rd_addr;
  word_t            word_eff;
  bit_idx_t         free_bit;
  word_t            alloc_word;
  bit_idx_t         rel_bit;
  logic             rel_in_range;
  logic             rel_live;
  logic             wr_en;
  word_t            wdata;

  assign accept  = req_i.valid && req_i.ready;
  assign advance = (state_q == ST_LOOK) && (!rsp_valid_q || rsp_o.ready);

  // Pick the word to read: first word with a free id, or the released id's word
  assign rd_addr = (req_i.kind == KIND_ALLOC) ? find_first_one(sum_q)
                                              : req_i.release_id[BitIdxW +: WordIdxW];

  // Unwritten words read as all free; padding above the id range counts as taken
  assign word_eff     = (vld_q[widx_q] ? rdata_q : '0) | pad_mask(widx_q);
  assign free_bit     = find_first_zero(word_eff);
  assign alloc_word   = word_eff | (word_t'(1) << free_bit);
  assign rel_bit      = rel_id_q[BitIdxW-1:0];
  assign rel_in_range = 32'(rel_id_q) < IdCount;
  assign rel_live     = rel_in_range && word_eff[rel_bit];

  // Write back on the advancing cycle of a state-changing request
  always_comb begin
    wr_en = 1'b0;
    wdata = word_eff;
    if (advance) begin
      case (kind_q)
        KIND_ALLOC: begin
          wr_en = !none_free_q;
          wdata = alloc_word;
        end
        KIND_RELEASE: begin
          wr_en = rel_live;
          wdata = word_eff & ~(word_t'(1) << rel_bit);
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Form the response fields of the item in lookup
  always_comb begin
    rsp_id_d     = '0;
    rsp_status_d = STATUS_DONE;
    case (kind_q)
      KIND_ALLOC: begin
        if (none_free_q) begin
          rsp_status_d = STATUS_FULL;
        end else begin
          rsp_id_d = IdW'({widx_q, free_bit});
        end
      end
      KIND_RELEASE: begin
        rsp_id_d = rel_id_q;
        if (!rel_live) rsp_status_d = STATUS_NOT_LIVE;
      end
      default: begin
      end
    endcase
  end

  // Bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[widx_q] <= wdata;
    if (accept) rdata_q <= mem[rd_addr];
  end

  // Hold the request while its word is read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= req_i.kind;
      rel_id_q    <= req_i.release_id;
      widx_q      <= rd_addr;
      none_free_q <= (sum_q == '0);
    end
  end

  // Sequence, summary, valid bits and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sum_q        <= '1;
      vld_q        <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_id_q     <= '0;
      rsp_status_q <= STATUS_DONE;
    end else begin
      if (advance) begin
        rsp_valid_q  <= 1'b1;
        rsp_id_q     <= rsp_id_d;
        rsp_status_q <= rsp_status_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q  <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) state_q <= ST_LOOK;
        end
        ST_LOOK: begin
          if (advance) begin
            state_q <= ST_IDLE;
            case (kind_q)
              KIND_ALLOC: begin
                if (!none_free_q) begin
                  vld_q[widx_q] <= 1'b1;
                  sum_q[widx_q] <= ~&alloc_word;
                end
              end
              KIND_RELEASE: begin
                if (rel_live) begin
                  vld_q[widx_q] <= 1'b1;
                  sum_q[widx_q] <= 1'b1;
                end
              end
              KIND_CLEAR: begin
                vld_q <= '0;
                sum_q <= '1;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.id      = rsp_id_q;
  assign rsp_o.status  = rsp_status_q;

  // A word flagged free in the summary must yield a free bit
  a_summary_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && kind_q == KIND_ALLOC && !none_free_q) |-> !(&word_eff))
    else $error("summary flags a word free but the word is full");

  // Summary after an allocation write reflects the written word
  a_summary_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && kind_q == KIND_ALLOC) |=> sum_q[$past(widx_q)] == !(&$past(wdata)))
    else $error("summary bit not updated from written word");

  // A full status is only given when the summary was empty at accept
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && kind_q == KIND_ALLOC) |=>
      ((rsp_status_q == STATUS_FULL) == $past(none_free_q)))
    else $error("full status disagrees with summary");

  // Only one item in flight: a request is never taken while a lookup runs
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOOK) && !req_i.ready)
    else $error("request accepted during lookup");

endmodule
